FILE: hdl/bpe_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bpe_pkg
// Shared types, field layout and sizing for the battery percent estimator.
// ============================================================================
package bpe_pkg;

    localparam int TABLE_ENTRIES = 101;
    localparam int FILTER_SHIFT  = 7;

    localparam int SMP_W   = 12;
    localparam int TIDX_W  = 7;
    localparam int LEVEL_W = 23;
    localparam int PCT_W   = 7;
    localparam int NOM_W   = 12;
    localparam int ACC_W   = 19;

    localparam int FLT_W  = ACC_W - FILTER_SHIFT;
    localparam int PROD_W = FLT_W + NOM_W;
    localparam int CNT_W  = $clog2(PROD_W);
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CMP_W  = ((TIDX_W > IDX_W) ? TIDX_W : IDX_W) + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // s_axis_tdata layout
    localparam int BAT_LSB  = 0;
    localparam int REF_LSB  = BAT_LSB + SMP_W;
    localparam int TIDX_LSB = REF_LSB + SMP_W;
    localparam int TVAL_LSB = TIDX_LSB + TIDX_W;
    localparam int IN_BITS  = TVAL_LSB + LEVEL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;

    // m_axis_tdata layout
    localparam int PCT_LSB = 0;
    localparam int LVL_LSB = PCT_LSB + PCT_W;
    localparam int OUT_BITS = LVL_LSB + LEVEL_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [NOM_W-1:0]   NOM_RESET = NOM_W'(1489);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CMP_W-1:0]   TBL_LIM   = CMP_W'(TABLE_ENTRIES);

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TABLE  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                kind;
        logic [FLT_W-1:0]   bat_flt;
        logic [FLT_W-1:0]   ref_flt;
        logic [IDX_W-1:0]   idx;
        logic [LEVEL_W-1:0] value;
    } t_job;

endpackage

FILE: hdl/battery_percent_estimator.sv
`timescale 1ns / 1ps
// ============================================================================
// battery_percent_estimator
// Battery gauge: moving-average filters, ratiometric correction, table lookup.
// ============================================================================
// A sample beat updates both moving-average filters at once and queues the
// work (none for a zero filtered reference); a table beat with an in-range
// index queues one threshold write. The back end handles one job at a time:
// a sample passes through pop, multiply, a bit-per-cycle restoring divide
// and a walk of the threshold table, each entry read from the registered-read
// memory and then compared, before the result is loaded into the output.
// A two-entry job queue lets the input keep accepting while a result waits
// on the output.
module battery_percent_estimator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bpe_pkg::NOM_W-1:0]     i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // from bit 0: battery_sample, reference_sample, table_index, table_value, zero pad
    input  logic [bpe_pkg::IN_W-1:0]      s_axis_tdata,
    // operation
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // from bit 0: percent, corrected_level, zero pad
    output logic [bpe_pkg::OUT_W-1:0]     m_axis_tdata
);

    logic                          q_full, q_push, q_valid, q_pop;
    bpe_pkg::t_job                 push_job, pop_job;
    logic [bpe_pkg::PCT_W-1:0]     percent;
    logic [bpe_pkg::LEVEL_W-1:0]   level;

    bpe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser[0]),
        .i_data  (s_axis_tdata),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (push_job)
    );

    bpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (pop_job)
    );

    bpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_job       (pop_job),
        .o_q_pop     (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_percent   (percent),
        .o_level     (level)
    );

    assign m_axis_tdata = bpe_pkg::OUT_W'({level, percent});

endmodule

FILE: hdl/bpe_front.sv
`timescale 1ns / 1ps
// ============================================================================
// bpe_front
// Accepts input beats, runs both moving-average filters and queues work.
// ============================================================================
module bpe_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_op,
    input  logic [bpe_pkg::IN_W-1:0]  i_data,
    input  logic                      i_full,
    output logic                      o_push,
    output bpe_pkg::t_job             o_job
);

    logic [bpe_pkg::ACC_W-1:0]  r_bat_acc, n_bat_acc;
    logic [bpe_pkg::ACC_W-1:0]  r_ref_acc, n_ref_acc;
    logic                       r_primed, n_primed;

    logic [bpe_pkg::SMP_W-1:0]   bat_s, ref_s;
    logic [bpe_pkg::TIDX_W-1:0]  tidx;
    logic                        accept;
    logic                        idx_ok;
    bpe_pkg::t_op                kind;

    assign bat_s  = i_data[bpe_pkg::BAT_LSB +: bpe_pkg::SMP_W];
    assign ref_s  = i_data[bpe_pkg::REF_LSB +: bpe_pkg::SMP_W];
    assign tidx   = i_data[bpe_pkg::TIDX_LSB +: bpe_pkg::TIDX_W];
    assign kind   = bpe_pkg::t_op'(i_op);
    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign idx_ok  = bpe_pkg::CMP_W'(tidx) < bpe_pkg::TBL_LIM;

    always_comb begin
        n_bat_acc = r_bat_acc;
        n_ref_acc = r_ref_acc;
        n_primed  = r_primed;
        if (accept && kind == bpe_pkg::OP_SAMPLE) begin
            if (!r_primed) begin
                n_bat_acc = bpe_pkg::ACC_W'(bat_s) << bpe_pkg::FILTER_SHIFT;
                n_ref_acc = bpe_pkg::ACC_W'(ref_s) << bpe_pkg::FILTER_SHIFT;
            end else begin
                n_bat_acc = r_bat_acc + bpe_pkg::ACC_W'(bat_s)
                          - (r_bat_acc >> bpe_pkg::FILTER_SHIFT);
                n_ref_acc = r_ref_acc + bpe_pkg::ACC_W'(ref_s)
                          - (r_ref_acc >> bpe_pkg::FILTER_SHIFT);
            end
            n_primed = 1'b1;
        end
    end

    always_comb begin
        o_job.kind    = kind;
        o_job.bat_flt = bpe_pkg::FLT_W'(n_bat_acc >> bpe_pkg::FILTER_SHIFT);
        o_job.ref_flt = bpe_pkg::FLT_W'(n_ref_acc >> bpe_pkg::FILTER_SHIFT);
        o_job.idx     = bpe_pkg::IDX_W'(tidx);
        o_job.value   = i_data[bpe_pkg::TVAL_LSB +: bpe_pkg::LEVEL_W];
        // zero reference: filters move on, nothing to report
        if (kind == bpe_pkg::OP_TABLE)
            o_push = accept && idx_ok;
        else
            o_push = accept && (o_job.ref_flt != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bat_acc <= '0;
            r_ref_acc <= '0;
            r_primed  <= 1'b0;
        end else begin
            r_bat_acc <= n_bat_acc;
            r_ref_acc <= n_ref_acc;
            r_primed  <= n_primed;
        end
    end

endmodule

FILE: hdl/bpe_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// bpe_queue
// Short FIFO of jobs between the front and back ends.
// ============================================================================
module bpe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bpe_pkg::t_job  i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output bpe_pkg::t_job  o_job
);

    bpe_pkg::t_job                 r_mem [bpe_pkg::QUEUE_DEPTH];
    logic [bpe_pkg::QPTR_W-1:0]    r_wptr, r_rptr;
    logic [bpe_pkg::QPTR_W:0]      r_count;

    logic do_push, do_pop;

    assign o_full  = r_count == (bpe_pkg::QPTR_W + 1)'(bpe_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push)
                r_wptr <= r_wptr + 1'b1;
            if (do_pop)
                r_rptr <= r_rptr + 1'b1;
            if (do_push && !do_pop)
                r_count <= r_count + 1'b1;
            else if (do_pop && !do_push)
                r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wptr] <= i_job;
    end

endmodule

FILE: hdl/bpe_back.sv
`timescale 1ns / 1ps
// ============================================================================
// bpe_back
// Ratiometric divide, threshold table walk and result register.
// ============================================================================
module bpe_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bpe_pkg::NOM_W-1:0]  i_cfg_wdata,
    input  logic                       i_q_valid,
    input  bpe_pkg::t_job              i_job,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [bpe_pkg::PCT_W-1:0]   o_percent,
    output logic [bpe_pkg::LEVEL_W-1:0] o_level
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_RD   = 6'b001000,
        ST_CMP  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state                         r_state, n_state;
    logic [bpe_pkg::NOM_W-1:0]      r_nom;
    logic [bpe_pkg::FLT_W-1:0]      r_bat, n_bat;
    logic [bpe_pkg::FLT_W-1:0]      r_ref, n_ref;
    logic [bpe_pkg::PROD_W-1:0]     r_q, n_q;
    logic [bpe_pkg::FLT_W-1:0]      r_rem, n_rem;
    logic [bpe_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [bpe_pkg::LEVEL_W-1:0]    r_level, n_level;
    logic [bpe_pkg::IDX_W-1:0]      r_addr, n_addr;
    logic                           r_tail, n_tail;
    logic [bpe_pkg::IDX_W-1:0]      r_pct, n_pct;
    logic                           r_ovalid, n_ovalid;
    logic [bpe_pkg::PCT_W-1:0]      r_opct, n_opct;
    logic [bpe_pkg::LEVEL_W-1:0]    r_olevel, n_olevel;
    logic [bpe_pkg::LEVEL_W-1:0]    r_rdata;
    logic [bpe_pkg::LEVEL_W-1:0]    r_tbl [bpe_pkg::TABLE_ENTRIES];

    logic [bpe_pkg::FLT_W:0]        rem_shift, rem_sub;
    logic                           rem_ge;
    logic [bpe_pkg::PROD_W-1:0]     q_next;
    logic                           tbl_we;
    logic                           out_free;

    assign o_valid   = r_ovalid;
    assign o_percent = r_opct;
    assign o_level   = r_olevel;

    assign rem_shift = {r_rem, r_q[bpe_pkg::PROD_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, r_ref};
    assign rem_sub   = rem_shift - {1'b0, r_ref};
    assign q_next    = {r_q[bpe_pkg::PROD_W-2:0], rem_ge};
    assign out_free  = !r_ovalid || i_ready;

    always_comb begin
        n_state  = r_state;
        n_bat    = r_bat;
        n_ref    = r_ref;
        n_q      = r_q;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_level  = r_level;
        n_addr   = r_addr;
        n_tail   = r_tail;
        n_pct    = r_pct;
        n_ovalid = r_ovalid;
        n_opct   = r_opct;
        n_olevel = r_olevel;
        o_q_pop  = 1'b0;
        tbl_we   = 1'b0;
        if (r_ovalid && i_ready)
            n_ovalid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_job.kind == bpe_pkg::OP_TABLE) begin
                        tbl_we = 1'b1;
                    end else begin
                        n_bat   = i_job.bat_flt;
                        n_ref   = i_job.ref_flt;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                n_q     = bpe_pkg::PROD_W'(r_bat) * bpe_pkg::PROD_W'(r_nom);
                n_rem   = '0;
                n_cnt   = bpe_pkg::CNT_W'(bpe_pkg::PROD_W - 1);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = rem_ge ? rem_sub[bpe_pkg::FLT_W-1:0]
                               : rem_shift[bpe_pkg::FLT_W-1:0];
                n_q   = q_next;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_level = (|(q_next >> bpe_pkg::LEVEL_W)) ? bpe_pkg::LEVEL_MAX
                                                              : bpe_pkg::LEVEL_W'(q_next);
                    n_addr  = '0;
                    n_tail  = 1'b0;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                // order: first entry, last entry, then scan from entry one up
                if (r_addr == '0 && !r_tail) begin
                    if (r_level <= r_rdata) begin
                        n_pct   = '0;
                        n_state = ST_OUT;
                    end else begin
                        n_addr  = bpe_pkg::LAST_IDX;
                        n_tail  = 1'b1;
                        n_state = ST_RD;
                    end
                end else if (r_tail) begin
                    if (r_level >= r_rdata || bpe_pkg::LAST_IDX == bpe_pkg::IDX_W'(1)) begin
                        n_pct   = bpe_pkg::LAST_IDX;
                        n_state = ST_OUT;
                    end else begin
                        n_addr  = bpe_pkg::IDX_W'(1);
                        n_tail  = 1'b0;
                        n_state = ST_RD;
                    end
                end else begin
                    if (r_level <= r_rdata) begin
                        n_pct   = r_addr;
                        n_state = ST_OUT;
                    end else if (r_addr == bpe_pkg::LAST_IDX - 1'b1) begin
                        n_pct   = bpe_pkg::LAST_IDX;
                        n_state = ST_OUT;
                    end else begin
                        n_addr  = r_addr + 1'b1;
                        n_state = ST_RD;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_opct   = bpe_pkg::PCT_W'(r_pct);
                    n_olevel = r_level;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_nom    <= bpe_pkg::NOM_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we)
                r_nom <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bat    <= n_bat;
        r_ref    <= n_ref;
        r_q      <= n_q;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_level  <= n_level;
        r_addr   <= n_addr;
        r_tail   <= n_tail;
        r_pct    <= n_pct;
        r_opct   <= n_opct;
        r_olevel <= n_olevel;
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we)
            r_tbl[i_job.idx] <= i_job.value;
        r_rdata <= r_tbl[r_addr];
    end

    a_div_ref_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_ref != '0))
        else $error("divide running with zero reference");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (r_addr <= bpe_pkg::LAST_IDX))
        else $error("table walk address out of range");

    a_out_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> ($past(r_state) == ST_CMP || $past(r_state) == ST_OUT))
        else $error("result stage entered without a table walk");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=> (r_ovalid && r_state == ST_IDLE))
        else $error("finished result not presented");

endmodule
